### rtl/planar_odometry_integrator_core_defines.svh
// Assertion macros shared by the odometry integrator RTL.
// Depends on nothing; the asserting module supplies i_clk and i_rst_n.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_DEFINES_SVH

// Implication checked in the same cycle.
`define POI_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odometry integrator assertion failed");

// Implication checked in the next cycle.
`define POI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odometry integrator assertion failed");

`endif

### rtl/poi_pkg.sv
// Types, fixed-point constants and the arctangent table of the odometry integrator.
// Depends on nothing; used by planar_odometry_integrator_core.
package poi_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORD_A,
        ST_ROT_FIX,
        ST_MATH,
        ST_WRAP,
        ST_CORD_B,
        ST_QUAT
    } t_state;

    localparam int VEL_W      = 24;
    localparam int RATE_W     = 21;
    localparam int DT_W       = 20;
    localparam int CX_W       = 33;
    localparam int ANG_W      = 32;
    localparam int MA_W       = 34;
    localparam int MB_W       = 25;
    localparam int PROD_W     = 59;
    localparam int ACC_W      = 62;
    localparam int RX_W       = 40;
    localparam int D_W        = 34;
    localparam int H_W        = 35;
    localparam int HEAD_W     = 31;
    localparam int Q_W        = 18;
    localparam int ATAN_IDX_W = 5;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 136;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = 32'sd843314857;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 32'sd421657428;
    localparam logic signed [ANG_W-1:0] FULL_TURN    = 32'sd1686629714;
    localparam logic signed [CX_W-1:0]  CORDIC_GAIN  = 33'sd652032874;
    localparam logic signed [CX_W-1:0]  QUAT_MAX     = 33'sd65536;

    function automatic logic signed [ANG_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd210828714;
            5'd1:    v = 32'sd124459457;
            5'd2:    v = 32'sd65760959;
            5'd3:    v = 32'sd33381290;
            5'd4:    v = 32'sd16755422;
            5'd5:    v = 32'sd8385879;
            5'd6:    v = 32'sd4193963;
            5'd7:    v = 32'sd2097109;
            5'd8:    v = 32'sd1048571;
            5'd9:    v = 32'sd524287;
            5'd10:   v = 32'sd262144;
            5'd11:   v = 32'sd131072;
            5'd12:   v = 32'sd65536;
            5'd13:   v = 32'sd32768;
            5'd14:   v = 32'sd16384;
            5'd15:   v = 32'sd8192;
            5'd16:   v = 32'sd4096;
            5'd17:   v = 32'sd2048;
            5'd18:   v = 32'sd1024;
            5'd19:   v = 32'sd512;
            5'd20:   v = 32'sd256;
            5'd21:   v = 32'sd128;
            5'd22:   v = 32'sd64;
            5'd23:   v = 32'sd32;
            5'd24:   v = 32'sd16;
            5'd25:   v = 32'sd8;
            5'd26:   v = 32'sd4;
            5'd27:   v = 32'sd2;
            5'd28:   v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/planar_odometry_integrator_core.sv
// Planar dead-reckoning odometry integrator: one shared CORDIC, one shared multiplier.
// Depends on poi_pkg and planar_odometry_integrator_core_defines.svh.
//
// Channel  Dir  Payload
// s_axis   in   vel_x, vel_y, yaw_rate, elapsed_ticks
// m_axis   out  pos_x, pos_y, heading, quat_z, quat_w; pos_saturated in tuser
//
// Each result is computed by two passes of the iterative CORDIC, twelve multiplier steps
// and up to four heading wrap steps. The input side takes one sample at a time; a finished
// result waits in the output register while the next sample is taken. Reset clears
// the pose to zero.
`include "planar_odometry_integrator_core_defines.svh"

module planar_odometry_integrator_core #(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_WIDTH    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vel_x[23:0], vel_y[47:24], yaw_rate[68:48], elapsed_ticks[88:69], zero fill
    input  logic [poi_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[94:64], quat_z[112:95], quat_w[130:113]
    output logic [poi_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // pos_saturated[0]
    output logic [0:0]                          m_axis_tuser
);

    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
    localparam int AW     = poi_pkg::ATAN_IDX_W;
    localparam int CX_W   = poi_pkg::CX_W;
    localparam int ANG_W  = poi_pkg::ANG_W;
    localparam int MA_W   = poi_pkg::MA_W;
    localparam int MB_W   = poi_pkg::MB_W;
    localparam int PROD_W = poi_pkg::PROD_W;
    localparam int ACC_W  = poi_pkg::ACC_W;
    localparam int RX_W   = poi_pkg::RX_W;
    localparam int D_W    = poi_pkg::D_W;
    localparam int H_W    = poi_pkg::H_W;
    localparam int Q_W    = poi_pkg::Q_W;
    localparam int VEL_W  = poi_pkg::VEL_W;
    localparam int RATE_W = poi_pkg::RATE_W;
    localparam int DT_W   = poi_pkg::DT_W;
    localparam int SUM_W  = ((POS_WIDTH > D_W) ? POS_WIDTH : D_W) + 1;
    localparam int EXT_W  = (POS_WIDTH > 32) ? POS_WIDTH : 32;

    localparam logic signed [SUM_W-1:0] POS_HI =
        {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_LO =
        {{(SUM_W - POS_WIDTH + 1){1'b1}}, {(POS_WIDTH - 1){1'b0}}};
    localparam logic signed [H_W-1:0] H_HALF = H_W'(poi_pkg::HALF_TURN);
    localparam logic signed [H_W-1:0] H_NHALF = -H_W'(poi_pkg::HALF_TURN);
    localparam logic signed [H_W-1:0] H_FULL = H_W'(poi_pkg::FULL_TURN);
    localparam logic signed [ANG_W-1:0] HEAD_MIN = -poi_pkg::HALF_TURN;
    localparam logic signed [ACC_W-1:0] RND8  = ACC_W'(1) <<< 7;
    localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(1) <<< 15;
    localparam logic signed [ACC_W-1:0] RND34 = ACC_W'(1) <<< 33;
    localparam logic signed [CX_W-1:0]  RND14 = CX_W'(1) <<< 13;

    localparam logic [3:0] MS_VXC   = 4'd0;
    localparam logic [3:0] MS_VYS   = 4'd1;
    localparam logic [3:0] MS_VXS   = 4'd2;
    localparam logic [3:0] MS_VYC   = 4'd3;
    localparam logic [3:0] MS_RXL   = 4'd4;
    localparam logic [3:0] MS_RXH   = 4'd5;
    localparam logic [3:0] MS_RYL   = 4'd6;
    localparam logic [3:0] MS_RYH   = 4'd7;
    localparam logic [3:0] MS_RATE  = 4'd8;
    localparam logic [3:0] MS_DY    = 4'd9;
    localparam logic [3:0] MS_POSY  = 4'd10;
    localparam logic [3:0] MS_HSUM  = 4'd11;

    poi_pkg::t_state r_state, n_state;
    logic [3:0]             r_step, n_step;
    logic [ITER_W-1:0]      r_iter, n_iter;
    logic                   r_out_valid, n_out_valid;

    logic signed [VEL_W-1:0]  r_vx, r_vy;
    logic signed [RATE_W-1:0] r_wr;
    logic [DT_W-1:0]          r_dt;
    logic signed [CX_W-1:0]   r_cx, r_cy, r_c, r_s;
    logic signed [ANG_W-1:0]  r_cz;
    logic                     r_neg;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [RX_W-1:0]   r_rx, r_ry;
    logic signed [D_W-1:0]    r_d;
    logic signed [H_W-1:0]    r_h;
    logic signed [ANG_W-1:0]  r_head;
    logic signed [POS_WIDTH-1:0] r_pos_x, r_pos_y;
    logic                     r_sat;
    logic [poi_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                     r_out_sat;

    logic                     in_xfer, load_out, iter_last, out_stall;
    logic signed [CX_W-1:0]   xs, ys, nx, ny;
    logic signed [ANG_W-1:0]  atan_v, nz, start_ang;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [ACC_W-1:0]  acc_r8, acc_r16, acc_r34;
    logic signed [POS_WIDTH-1:0] sat_in, sat_res;
    logic signed [SUM_W-1:0]  sat_sum;
    logic                     sat_hit;
    logic signed [CX_W-1:0]   qz_sh, qw_sh, qz_cl, qw_cl;
    logic signed [EXT_W-1:0]  px_ext, py_ext;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign iter_last = (r_iter == ITER_LAST);
    assign out_stall = (r_state == poi_pkg::ST_QUAT) && r_out_valid && !m_axis_tready;

    // Shared CORDIC rotation step.
    always_comb begin
        xs     = r_cx >>> r_iter;
        ys     = r_cy >>> r_iter;
        atan_v = poi_pkg::atan_q28(AW'(r_iter));
        if (r_cz >= 0) begin
            nx = r_cx - ys;
            ny = r_cy + xs;
            nz = r_cz - atan_v;
        end else begin
            nx = r_cx + ys;
            ny = r_cy - xs;
            nz = r_cz + atan_v;
        end
    end

    always_comb begin
        if (r_head > poi_pkg::QUARTER_TURN) begin
            start_ang = r_head - poi_pkg::HALF_TURN;
        end else if (r_head < -poi_pkg::QUARTER_TURN) begin
            start_ang = r_head + poi_pkg::HALF_TURN;
        end else begin
            start_ang = r_head;
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            MS_VXC: begin
                mul_a = MA_W'(r_c);
                mul_b = MB_W'(r_vx);
            end
            MS_VYS: begin
                mul_a = MA_W'(r_s);
                mul_b = MB_W'(r_vy);
            end
            MS_VXS: begin
                mul_a = MA_W'(r_s);
                mul_b = MB_W'(r_vx);
            end
            MS_VYC: begin
                mul_a = MA_W'(r_c);
                mul_b = MB_W'(r_vy);
            end
            MS_RXL: begin
                mul_a = {{(MA_W - 16){1'b0}}, r_rx[15:0]};
                mul_b = {{(MB_W - DT_W){1'b0}}, r_dt};
            end
            MS_RXH: begin
                mul_a = MA_W'(r_rx >>> 16);
                mul_b = {{(MB_W - DT_W){1'b0}}, r_dt};
            end
            MS_RYL: begin
                mul_a = {{(MA_W - 16){1'b0}}, r_ry[15:0]};
                mul_b = {{(MB_W - DT_W){1'b0}}, r_dt};
            end
            MS_RYH: begin
                mul_a = MA_W'(r_ry >>> 16);
                mul_b = {{(MB_W - DT_W){1'b0}}, r_dt};
            end
            MS_RATE: begin
                mul_a = MA_W'(r_wr);
                mul_b = {{(MB_W - DT_W){1'b0}}, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_r8  = (r_acc + RND8) >>> 8;
    assign acc_r16 = (r_acc + RND16) >>> 16;
    assign acc_r34 = (r_acc + RND34) >>> 34;

    // Shared saturating position adder.
    always_comb begin
        sat_in  = (r_step == MS_RATE) ? r_pos_x : r_pos_y;
        sat_sum = SUM_W'(sat_in) + SUM_W'(r_d);
        sat_hit = 1'b0;
        if (sat_sum > POS_HI) begin
            sat_res = POS_HI[POS_WIDTH-1:0];
            sat_hit = 1'b1;
        end else if (sat_sum < POS_LO) begin
            sat_res = POS_LO[POS_WIDTH-1:0];
            sat_hit = 1'b1;
        end else begin
            sat_res = sat_sum[POS_WIDTH-1:0];
        end
    end

    always_comb begin
        qz_sh = (r_cy + RND14) >>> 14;
        qw_sh = (r_cx + RND14) >>> 14;
        if (qz_sh > poi_pkg::QUAT_MAX) begin
            qz_cl = poi_pkg::QUAT_MAX;
        end else if (qz_sh < -poi_pkg::QUAT_MAX) begin
            qz_cl = -poi_pkg::QUAT_MAX;
        end else begin
            qz_cl = qz_sh;
        end
        if (qw_sh > poi_pkg::QUAT_MAX) begin
            qw_cl = poi_pkg::QUAT_MAX;
        end else if (qw_sh < -poi_pkg::QUAT_MAX) begin
            qw_cl = -poi_pkg::QUAT_MAX;
        end else begin
            qw_cl = qw_sh;
        end
        px_ext = EXT_W'(r_pos_x);
        py_ext = EXT_W'(r_pos_y);
    end

    // Sequencer.
    always_comb begin
        n_state       = r_state;
        n_step        = r_step;
        n_iter        = '0;
        load_out      = 1'b0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            poi_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = poi_pkg::ST_CORD_A;
                end
            end
            poi_pkg::ST_CORD_A: begin
                if (iter_last) begin
                    n_state = poi_pkg::ST_ROT_FIX;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            poi_pkg::ST_ROT_FIX: begin
                n_state = poi_pkg::ST_MATH;
                n_step  = MS_VXC;
            end
            poi_pkg::ST_MATH: begin
                if (r_step == MS_HSUM) begin
                    n_state = poi_pkg::ST_WRAP;
                    n_step  = MS_VXC;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            poi_pkg::ST_WRAP: begin
                if (r_h < H_HALF && r_h >= H_NHALF) begin
                    n_state = poi_pkg::ST_CORD_B;
                end
            end
            poi_pkg::ST_CORD_B: begin
                if (iter_last) begin
                    n_state = poi_pkg::ST_QUAT;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            poi_pkg::ST_QUAT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = poi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = poi_pkg::ST_IDLE;
            end
        endcase
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= poi_pkg::ST_IDLE;
            r_step      <= MS_VXC;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

    // Pose state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_head  <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_sat <= 1'b0;
            end
            if (r_state == poi_pkg::ST_MATH && r_step == MS_RATE) begin
                r_pos_x <= sat_res;
                r_sat   <= r_sat | sat_hit;
            end
            if (r_state == poi_pkg::ST_MATH && r_step == MS_POSY) begin
                r_pos_y <= sat_res;
                r_sat   <= r_sat | sat_hit;
            end
            if (r_state == poi_pkg::ST_WRAP && r_h < H_HALF && r_h >= H_NHALF) begin
                r_head <= r_h[ANG_W-1:0];
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            poi_pkg::ST_IDLE: begin
                r_vx  <= s_axis_tdata[23:0];
                r_vy  <= s_axis_tdata[47:24];
                r_wr  <= s_axis_tdata[68:48];
                r_dt  <= s_axis_tdata[88:69];
                r_cx  <= poi_pkg::CORDIC_GAIN;
                r_cy  <= '0;
                r_cz  <= start_ang;
                r_neg <= (r_head > poi_pkg::QUARTER_TURN)
                      || (r_head < -poi_pkg::QUARTER_TURN);
            end
            poi_pkg::ST_CORD_A, poi_pkg::ST_CORD_B: begin
                r_cx <= nx;
                r_cy <= ny;
                r_cz <= nz;
            end
            poi_pkg::ST_ROT_FIX: begin
                r_c <= r_neg ? -r_cx : r_cx;
                r_s <= r_neg ? -r_cy : r_cy;
            end
            poi_pkg::ST_MATH: begin
                case (r_step)
                    MS_VYS: r_acc <= ACC_W'(r_prod);
                    MS_VXS: r_acc <= r_acc - ACC_W'(r_prod);
                    MS_VYC: begin
                        r_rx  <= acc_r16[RX_W-1:0];
                        r_acc <= ACC_W'(r_prod);
                    end
                    MS_RXL: r_acc <= r_acc + ACC_W'(r_prod);
                    MS_RXH: begin
                        r_ry  <= acc_r16[RX_W-1:0];
                        r_acc <= ACC_W'(r_prod);
                    end
                    MS_RYL: r_acc <= r_acc + (ACC_W'(r_prod) <<< 16);
                    MS_RYH: begin
                        r_d   <= acc_r34[D_W-1:0];
                        r_acc <= ACC_W'(r_prod);
                    end
                    MS_RATE: r_acc <= r_acc + (ACC_W'(r_prod) <<< 16);
                    MS_DY: begin
                        r_d   <= acc_r34[D_W-1:0];
                        r_acc <= ACC_W'(r_prod);
                    end
                    MS_POSY: r_d <= acc_r8[D_W-1:0];
                    MS_HSUM: r_h <= H_W'(r_head) + H_W'(r_d);
                    default: r_acc <= r_acc;
                endcase
            end
            poi_pkg::ST_WRAP: begin
                if (r_h >= H_HALF) begin
                    r_h <= r_h - H_FULL;
                end else if (r_h < H_NHALF) begin
                    r_h <= r_h + H_FULL;
                end else begin
                    r_cx <= poi_pkg::CORDIC_GAIN;
                    r_cy <= '0;
                    r_cz <= ANG_W'(r_h >>> 1);
                end
            end
            default: begin
                r_cx <= r_cx;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {5'd0, qw_cl[Q_W-1:0], qz_cl[Q_W-1:0],
                           r_head[poi_pkg::HEAD_W-1:0], py_ext[31:0], px_ext[31:0]};
            r_out_sat  <= r_sat;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_sat;

    `POI_ASSERT_NOW(a_head_range, 1'b1, (r_head >= HEAD_MIN) && (r_head < poi_pkg::HALF_TURN))
    `POI_ASSERT_NOW(a_iter_bound, 1'b1, r_iter <= ITER_LAST)
    `POI_ASSERT_NEXT(a_start_cordic, in_xfer, (r_state == poi_pkg::ST_CORD_A) && (r_iter == '0))
    `POI_ASSERT_NEXT(a_hold_result, out_stall, r_state == poi_pkg::ST_QUAT)

endmodule

### test/tb_planar_odometry_integrator_core.sv
// Self-checking testbench for planar_odometry_integrator_core: a directed table, then random
// wandering and long straight sprints into the position limits, checked by a bit-exact pose model.
// Depends on poi_pkg and the RTL of planar_odometry_integrator_core.
module tb_planar_odometry_integrator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CORDIC_STEPS  = 16;
    localparam int POS_WIDTH     = 32;
    localparam int CLK_HALF      = 5;
    localparam int LATENCY_MAX   = 2 * CORDIC_STEPS + 19;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int EAST_START    = 350;
    localparam int EAST_END      = 680;
    localparam int SOUTH_START   = 900;
    localparam int SOUTH_END     = 1230;
    localparam int POSE_BITS     = 131;
    localparam int ATAN_ENTRIES  = 30;

    localparam longint HALF_TURN_Q28    = 64'sd843314857;
    localparam longint FULL_TURN_Q28    = 2 * HALF_TURN_Q28;
    localparam longint QUARTER_TURN_Q28 = 64'sd421657428;
    localparam longint CORDIC_START_X   = 64'sd652032874;
    localparam longint QUAT_LIMIT       = 64'sd65536;
    localparam longint VEL_TOP          = 64'sd8388607;

    localparam logic signed [23:0] VEL_MAX      = 24'sh7FFFFF;
    localparam logic signed [23:0] VEL_MIN      = 24'sh800000;
    localparam logic signed [20:0] RATE_MAX     = 21'sh0FFFFF;
    localparam logic signed [20:0] RATE_MIN     = 21'sh100000;
    localparam logic signed [20:0] QUARTER_RATE = 21'sd205888;
    localparam logic [19:0]        TICKS_MAX    = 20'hFFFFF;

    typedef struct packed {
        logic [19:0]        ticks;
        logic signed [20:0] yaw_rate;
        logic signed [23:0] vel_y;
        logic signed [23:0] vel_x;
    } sample_t;

    typedef struct packed {
        logic               pos_saturated;
        logic signed [17:0] quat_w;
        logic signed [17:0] quat_z;
        logic signed [30:0] heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } pose_t;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // vel_x[23:0], vel_y[47:24], yaw_rate[68:48], elapsed_ticks[88:69], zero fill
    logic [poi_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // pos_x[31:0], pos_y[63:32], heading[94:64], quat_z[112:95], quat_w[130:113]
    logic [poi_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    // pos_saturated[0]
    logic [0:0]                      m_axis_tuser;

    longint pose_x = 0;
    longint pose_y = 0;
    longint pose_heading = 0;
    pose_t  pending_poses[$];
    int     send_calm = 0;
    int     recv_calm = 0;
    int     samples_sent = 0;
    int     poses_checked = 0;
    int     clipped_poses = 0;
    int     heading_wraps = 0;
    int     mismatches = 0;
    int     cycle_count = 0;

    planar_odometry_integrator_core #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .POS_WIDTH   (POS_WIDTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d poses outstanding.",
                     cycle_count, pending_poses.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint arctan_q28(input int idx);
        case (idx)
            0:       return 210828714;
            1:       return 124459457;
            2:       return 65760959;
            3:       return 33381290;
            4:       return 16755422;
            5:       return 8385879;
            6:       return 4193963;
            7:       return 2097109;
            8:       return 1048571;
            9:       return 524287;
            10:      return 262144;
            11:      return 131072;
            12:      return 65536;
            13:      return 32768;
            14:      return 16384;
            15:      return 8192;
            16:      return 4096;
            17:      return 2048;
            18:      return 1024;
            19:      return 512;
            20:      return 256;
            21:      return 128;
            22:      return 64;
            23:      return 32;
            24:      return 16;
            25:      return 8;
            26:      return 4;
            27:      return 2;
            28:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint round_shr(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic void cordic_rotate(input longint angle, output longint cos_q30,
                                          output longint sin_q30);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        int     i;
        x = CORDIC_START_X;
        y = 0;
        z = angle;
        for (i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q28(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q28(i);
            end
        end
        cos_q30 = x;
        sin_q30 = y;
    endfunction

    // The rotator only converges near zero, so headings beyond a quarter turn are folded by pi.
    function automatic void heading_sincos(input longint h, output longint c, output longint s);
        if (h > QUARTER_TURN_Q28 || h < -QUARTER_TURN_Q28) begin
            cordic_rotate(h > 0 ? h - HALF_TURN_Q28 : h + HALF_TURN_Q28, c, s);
            c = -c;
            s = -s;
        end else begin
            cordic_rotate(h, c, s);
        end
    endfunction

    function automatic longint clip_position(input longint v);
        longint hi;
        hi = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint clip_quat(input longint v);
        longint q;
        q = round_shr(v, 14);
        if (q > QUAT_LIMIT) return QUAT_LIMIT;
        if (q < -QUAT_LIMIT) return -QUAT_LIMIT;
        return q;
    endfunction

    function automatic void integrate_pose(input sample_t smp, output pose_t res);
        longint vx;
        longint vy;
        longint wr;
        longint dt;
        longint c;
        longint s;
        longint rx;
        longint ry;
        longint nx;
        longint ny;
        longint h;
        longint r;
        longint qc;
        longint qs;
        vx = longint'(smp.vel_x);
        vy = longint'(smp.vel_y);
        wr = longint'(smp.yaw_rate);
        dt = longint'(smp.ticks);
        heading_sincos(pose_heading, c, s);
        rx = round_shr(vx * c - vy * s, 16);
        ry = round_shr(vx * s + vy * c, 16);
        nx = pose_x + round_shr(rx * dt, 34);
        ny = pose_y + round_shr(ry * dt, 34);
        pose_x = clip_position(nx);
        pose_y = clip_position(ny);
        res.pos_saturated = (pose_x != nx) || (pose_y != ny);

        h = pose_heading + round_shr(wr * dt, 8);
        r = (h + HALF_TURN_Q28) % FULL_TURN_Q28;
        if (r < 0) r = r + FULL_TURN_Q28;
        pose_heading = r - HALF_TURN_Q28;
        if (pose_heading != h) heading_wraps++;

        cordic_rotate(pose_heading >>> 1, qc, qs);
        qc = clip_quat(qc);
        qs = clip_quat(qs);
        res.pos_x   = pose_x[31:0];
        res.pos_y   = pose_y[31:0];
        res.heading = pose_heading[30:0];
        res.quat_z  = qs[17:0];
        res.quat_w  = qc[17:0];
    endfunction

    function automatic sample_t sample_of(input logic signed [23:0] vx,
                                          input logic signed [23:0] vy,
                                          input logic signed [20:0] yr, input logic [19:0] dt);
        sample_t smp;
        smp.vel_x    = vx;
        smp.vel_y    = vy;
        smp.yaw_rate = yr;
        smp.ticks    = dt;
        return smp;
    endfunction

    // Rows flagged as zero pose must leave the pose at the origin with no clipping.
    task automatic directed_row(input int idx, output sample_t smp, output bit zero_pose);
        zero_pose = 1'b0;
        case (idx)
            0: begin
                smp = sample_of(0, 0, 0, 0);
                zero_pose = 1'b1;
            end
            1: begin
                smp = sample_of(VEL_MAX, VEL_MIN, RATE_MAX, 0);
                zero_pose = 1'b1;
            end
            2: begin
                smp = sample_of(0, 0, 0, TICKS_MAX);
                zero_pose = 1'b1;
            end
            3:  smp = sample_of(VEL_MAX, 0, 0, TICKS_MAX);
            4:  smp = sample_of(VEL_MIN, 0, 0, TICKS_MAX);
            5:  smp = sample_of(0, VEL_MAX, 0, TICKS_MAX);
            6:  smp = sample_of(0, VEL_MIN, 0, TICKS_MAX);
            7:  smp = sample_of(0, 0, RATE_MAX, TICKS_MAX);
            8:  smp = sample_of(VEL_MAX, VEL_MAX, 0, TICKS_MAX);
            9:  smp = sample_of(0, 0, RATE_MIN, TICKS_MAX);
            10: smp = sample_of(VEL_MIN, VEL_MIN, 0, TICKS_MAX);
            11: smp = sample_of(0, 0, 21'sd1, 20'd1);
            12: smp = sample_of(-24'sd1, -24'sd1, -21'sd1, 20'd1);
            13, 14, 15, 16: smp = sample_of(VEL_MAX, 24'sd12345, QUARTER_RATE, 20'h80000);
            17: smp = sample_of(24'sh555555, 24'shAAAAAA, 21'sh0AAAAA, 20'h55555);
            18: smp = sample_of(24'shAAAAAA, 24'sh555555, 21'sh155555, 20'hAAAAA);
            19: smp = sample_of(VEL_MAX, VEL_MAX, RATE_MAX, TICKS_MAX);
            20: smp = sample_of(VEL_MIN, VEL_MIN, RATE_MIN, TICKS_MAX);
            default: smp = sample_of(VEL_MAX, VEL_MIN, RATE_MIN, TICKS_MAX);
        endcase
    endtask

    function automatic sample_t wander_sample();
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [20:0] yr;
        logic [19:0]        dt;
        int                 pick;
        if ($urandom_range(0, 9) < 7) begin
            vx = 24'($urandom);
            vy = 24'($urandom);
        end else begin
            vx = 24'(longint'($urandom_range(0, 131072)) - 65536);
            vy = 24'(longint'($urandom_range(0, 131072)) - 65536);
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) yr = 21'($urandom);
        else if (pick < 8) yr = 21'(longint'($urandom_range(0, 8192)) - 4096);
        else yr = 0;
        pick = $urandom_range(0, 9);
        if (pick == 0) dt = 0;
        else if (pick < 4) dt = 20'($urandom_range(0, 4095));
        else if (pick < 8) dt = 20'($urandom);
        else dt = 20'($urandom_range(TICKS_MAX - 4095, TICKS_MAX));
        return sample_of(vx, vy, yr, dt);
    endfunction

    function automatic longint clamp_vel(input longint v);
        if (v > VEL_TOP) return VEL_TOP;
        if (v < -VEL_TOP - 1) return -VEL_TOP - 1;
        return v;
    endfunction

    // Body velocity that moves the robot along world direction (dx, dy) at nearly full speed.
    function automatic sample_t sprint_sample(input longint dx, input longint dy);
        longint c;
        longint s;
        longint speed;
        longint bx;
        longint by;
        heading_sincos(pose_heading, c, s);
        speed = VEL_TOP - $urandom_range(0, 32767);
        bx = clamp_vel((c * dx * speed + s * dy * speed) >>> 30);
        by = clamp_vel((c * dy * speed - s * dx * speed) >>> 30);
        return sample_of(bx[23:0], by[23:0], 0,
                         20'($urandom_range(TICKS_MAX - 65535, TICKS_MAX)));
    endfunction

    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 23) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic transfer_sample(input sample_t smp, input bit zero_pose, input bit drain_first);
        int    gap;
        pose_t want;
        gap = draw_wait(send_calm);
        if (drain_first && gap == 0) gap = 1;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (drain_first) begin
            while (pending_poses.size() != 0) @(posedge i_clk);
        end
        s_axis_tdata  <= poi_pkg::IN_DATA_W'(smp);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        integrate_pose(smp, want);
        if (zero_pose) begin
            want.pos_x         = 0;
            want.pos_y         = 0;
            want.heading       = 0;
            want.pos_saturated = 1'b0;
        end
        pending_poses.push_back(want);
        samples_sent++;
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Pose %0d: %s expected %0d, got %0d", poses_checked, name, want, got);
        end
    endtask

    initial begin
        int      gap;
        pose_t   got;
        pose_t   want;
        wait (i_rst_n);
        forever begin
            gap = draw_wait(recv_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = {m_axis_tuser[0], m_axis_tdata[POSE_BITS-1:0]};
            if (got.pos_saturated) clipped_poses++;
            if (pending_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Pose %0d arrived with no input outstanding.", poses_checked);
            end else begin
                want = pending_poses.pop_front();
                compare_field("pos_x", want.pos_x, got.pos_x);
                compare_field("pos_y", want.pos_y, got.pos_y);
                compare_field("heading", want.heading, got.heading);
                compare_field("quat_z", want.quat_z, got.quat_z);
                compare_field("quat_w", want.quat_w, got.quat_w);
                compare_field("pos_saturated", want.pos_saturated, got.pos_saturated);
            end
            poses_checked++;
        end
    end

    initial begin
        sample_t smp;
        bit      zero_pose;
        bit      drain;
        int      n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIRECTED_ROWS; n++) begin
            directed_row(n, smp, zero_pose);
            transfer_sample(smp, zero_pose, 1'b0);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            drain = (n == 0) || (n == EAST_START) || (n == EAST_END) || (n == SOUTH_START)
                    || (n == SOUTH_END) || ($urandom_range(0, 63) == 0);
            if (n >= EAST_START && n < EAST_END) smp = sprint_sample(1, 0);
            else if (n >= SOUTH_START && n < SOUTH_END) smp = sprint_sample(0, -1);
            else smp = wander_sample();
            transfer_sample(smp, 1'b0, drain);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY_MAX) @(posedge i_clk);

        $display("Integrated %0d velocity samples and checked %0d poses in %0d cycles.",
                 samples_sent, poses_checked, cycle_count);
        $display("%0d poses hit a position limit and %0d heading updates wrapped around pi.",
                 clipped_poses, heading_wraps);
        if (mismatches == 0 && pending_poses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d poses never arrived.", mismatches,
                     pending_poses.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
